FILE: design/brb_pkg.sv
// Shared types and constants for the broadcast ring buffer.
`default_nettype none
package brb_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int CONSUMERS_DEF = 8;
  localparam int DATA_W_DEF    = 16;

  localparam int CNT_W      = 16;
  localparam int CID_W      = 3;
  localparam int SLOTS_CW   = 5;
  localparam int CONS_CW    = 4;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [SLOTS_CW-1:0] SLOTS_RST = 5'd16;
  localparam logic [CONS_CW-1:0]  CONS_RST  = 4'd8;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic REG_SLOTS     = 1'b0;
  localparam logic REG_CONSUMERS = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE        = 2'd0,
    ST_SLOT_BUSY   = 2'd1,
    ST_NOTHING_NEW = 2'd2,
    ST_BAD_ID      = 2'd3
  } status_t;

endpackage
`default_nettype wire

FILE: design/broadcast_ring_buffer.sv
// Broadcast ring buffer: a slot ring read once by every active consumer before reuse.
`default_nettype none
// One access (write or consumer read) is accepted per cycle and its result
// is loaded into the output register on acceptance; the block sustains one
// access per cycle whenever the output side takes each result. The figure is
// set by the update of the slot pending counts, pointers and counters in the
// accept cycle, and by the item store, a synchronous RAM read in that cycle.
// A refused access (slot busy, nothing new, consumer not active) changes no
// state and returns zero data. Configuration through the APB port takes effect
// on the next accepted access; the block needs no clearing pass after reset.
module broadcast_ring_buffer #(
  parameter int SLOTS      = brb_pkg::SLOTS_DEF,
  parameter int CONSUMERS  = brb_pkg::CONSUMERS_DEF,
  parameter int DATA_WIDTH = brb_pkg::DATA_W_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [brb_pkg::APB_AW-1:0]   paddr,
  input  wire logic [brb_pkg::APB_DW-1:0]   pwdata,
  output logic      [brb_pkg::APB_DW-1:0]   prdata,
  output logic                              pready,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         opcode,
  input  wire logic [brb_pkg::CID_W-1:0]    consumer_id,
  input  wire logic [DATA_WIDTH-1:0]        data_in,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output brb_pkg::status_t                  status,
  output logic      [DATA_WIDTH-1:0]        data_out
);
  import brb_pkg::*;

  localparam int PW  = $clog2(SLOTS);
  localparam int ESW = PW + 1;
  localparam int PCW = $clog2(CONSUMERS + 1);
  localparam int CIW = (CONSUMERS > 1) ? $clog2(CONSUMERS) : 1;

  logic [SLOTS_CW-1:0] slots_in_use;
  logic [CONS_CW-1:0]  consumers_in_use;

  logic [DATA_WIDTH-1:0] item_store [SLOTS];
  logic [DATA_WIDTH-1:0] mem_q;
  logic [PCW-1:0]        pending_readers [SLOTS];
  logic [PW-1:0]         write_pointer;
  logic [PW-1:0]         read_pointers [CONSUMERS];
  logic [CNT_W-1:0]      produced_count;
  logic [CNT_W-1:0]      consumed_counts [CONSUMERS];
  logic                  rd_ok;

  logic            accept;
  logic            cfg_we;
  logic [ESW-1:0]  eff_slots;
  logic [PCW-1:0]  eff_cons;
  logic [CIW-1:0]  cidx;
  logic [PW-1:0]   rp;
  logic [ESW-1:0]  wp_inc;
  logic [ESW-1:0]  rp_inc;
  logic [PW-1:0]   wp_next;
  logic [PW-1:0]   rp_next;
  logic            do_write;
  logic            do_read;
  status_t         status_next;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use     <= SLOTS_RST;
      consumers_in_use <= CONS_RST;
    end else if (cfg_we) begin
      if (paddr[2] == REG_SLOTS) begin
        slots_in_use <= pwdata[SLOTS_CW-1:0];
      end else begin
        consumers_in_use <= pwdata[CONS_CW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_CONSUMERS) begin
      prdata = APB_DW'(consumers_in_use);
    end else begin
      prdata = APB_DW'(slots_in_use);
    end
  end

  always_comb begin
    if (slots_in_use == '0) begin
      eff_slots = ESW'(1);
    end else if (32'(slots_in_use) > SLOTS) begin
      eff_slots = ESW'(SLOTS);
    end else begin
      eff_slots = ESW'(slots_in_use);
    end
    if (consumers_in_use == '0) begin
      eff_cons = PCW'(1);
    end else if (32'(consumers_in_use) > CONSUMERS) begin
      eff_cons = PCW'(CONSUMERS);
    end else begin
      eff_cons = PCW'(consumers_in_use);
    end
  end

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign cidx     = CIW'(consumer_id);
  assign rp       = read_pointers[cidx];

  assign wp_inc  = {1'b0, write_pointer} + ESW'(1);
  assign rp_inc  = {1'b0, rp} + ESW'(1);
  assign wp_next = (wp_inc >= eff_slots) ? '0 : wp_inc[PW-1:0];
  assign rp_next = (rp_inc >= eff_slots) ? '0 : rp_inc[PW-1:0];

  always_comb begin
    do_write    = 1'b0;
    do_read     = 1'b0;
    status_next = ST_DONE;
    if (opcode == OP_WRITE) begin
      if (pending_readers[write_pointer] != '0) begin
        status_next = ST_SLOT_BUSY;
      end else begin
        do_write = accept;
      end
    end else begin
      if (32'(consumer_id) >= 32'(eff_cons)) begin
        status_next = ST_BAD_ID;
      end else if (pending_readers[rp] == '0 || consumed_counts[cidx] == produced_count) begin
        status_next = ST_NOTHING_NEW;
      end else begin
        do_read = accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      item_store[write_pointer] <= data_in;
    end
    if (do_read) begin
      mem_q <= item_store[rp];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        pending_readers[i] <= '0;
      end
      for (int i = 0; i < CONSUMERS; i++) begin
        read_pointers[i]   <= '0;
        consumed_counts[i] <= '0;
      end
      write_pointer  <= '0;
      produced_count <= '0;
    end else begin
      if (do_write) begin
        pending_readers[write_pointer] <= eff_cons;
        produced_count                 <= produced_count + CNT_W'(1);
        write_pointer                  <= wp_next;
      end
      if (do_read) begin
        pending_readers[rp]    <= pending_readers[rp] - PCW'(1);
        consumed_counts[cidx]  <= consumed_counts[cidx] + CNT_W'(1);
        read_pointers[cidx]    <= rp_next;
      end
    end
  end

  // hold the result while stalled, load on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rd_ok     <= 1'b0;
      status    <= ST_DONE;
    end else if (accept) begin
      out_valid <= 1'b1;
      rd_ok     <= do_read;
      status    <= status_next;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign data_out = rd_ok ? mem_q : '0;

endmodule
`default_nettype wire

FILE: design/brb_checker.sv
// Port-level checks for the broadcast ring buffer, bound to the top level.
`default_nettype none
module brb_checker #(
  parameter int DATA_WIDTH = brb_pkg::DATA_W_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire brb_pkg::status_t      status,
  input wire logic [DATA_WIDTH-1:0] data_out
);
  import brb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_DONE |-> data_out == '0)
    else $error("refused access returned data");

  a_in_stall_src: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat present after reset");

  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted beat gave no result");

endmodule

bind broadcast_ring_buffer brb_checker #(.DATA_WIDTH(DATA_WIDTH)) u_brb_checker (.*);
`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 100ps
// Testbench for broadcast_ring_buffer: bursty access beats checked against a ring predictor.
module tb;
  import brb_pkg::*;

  localparam int NSLOT = SLOTS_DEF;
  localparam int NCONS = CONSUMERS_DEF;
  localparam int DW = DATA_W_DEF;
  localparam int PW = $clog2(NSLOT);
  localparam int LIMIT = 2_000_000;
  localparam int SINGLE_PAIRS = 8;
  localparam logic [APB_AW-1:0] ADDR_SLOTS = {REG_SLOTS, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_CONS = {REG_CONSUMERS, 2'b00};

  typedef struct packed {
    logic           op;
    logic [CID_W-1:0] cid;
    logic [DW-1:0]  din;
  } access_t;

  typedef struct packed {
    status_t       st;
    logic [DW-1:0] dout;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = OP_WRITE;
  logic [CID_W-1:0] consumer_id = '0;
  logic [DW-1:0] data_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  status_t status;
  logic [DW-1:0] data_out;

  broadcast_ring_buffer dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .consumer_id(consumer_id), .data_in(data_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .data_out(data_out)
  );

  always #6 clk = ~clk;

  // ring predictor state
  logic [DW-1:0]       ring_data [NSLOT];
  logic [3:0]          ring_pend [NSLOT];
  logic [PW-1:0]       wr_ptr;
  logic [PW-1:0]       rd_ptr [NCONS];
  logic [CNT_W-1:0]    items_made;
  logic [CNT_W-1:0]    items_taken [NCONS];
  logic [SLOTS_CW-1:0] cfg_slots = SLOTS_RST;
  logic [CONS_CW-1:0]  cfg_cons = CONS_RST;

  access_t  access_q [$];
  outcome_t outcome_q [$];
  access_t  cur;
  int gap_left = 0;
  int burst_left = 1;
  int free_left = 0;
  int stall_left = 0;
  int max_gap = 6;
  int max_stall = 5;
  int cycles = 0;
  int mismatches = 0;

  function automatic int ring_len();
    if (cfg_slots < 1) return 1;
    if (cfg_slots > NSLOT) return NSLOT;
    return cfg_slots;
  endfunction

  function automatic int reader_count();
    if (cfg_cons < 1) return 1;
    if (cfg_cons > NCONS) return NCONS;
    return cfg_cons;
  endfunction

  function automatic logic [PW-1:0] step_ptr(input logic [PW-1:0] p);
    int n;
    n = p + 1;
    return (n >= ring_len()) ? '0 : PW'(n);
  endfunction

  function automatic outcome_t ring_access(input access_t a);
    outcome_t r;
    logic [PW-1:0] p;
    r.st = ST_DONE;
    r.dout = '0;
    if (a.op == OP_WRITE) begin
      p = wr_ptr;
      if (ring_pend[p] != 0) begin
        r.st = ST_SLOT_BUSY;
      end else begin
        ring_data[p] = a.din;
        ring_pend[p] = 4'(reader_count());
        items_made = items_made + 1'b1;
        wr_ptr = step_ptr(p);
      end
    end else if (a.cid >= reader_count()) begin
      r.st = ST_BAD_ID;
    end else begin
      p = rd_ptr[a.cid];
      if (ring_pend[p] == 0 || items_taken[a.cid] == items_made) begin
        r.st = ST_NOTHING_NEW;
      end else begin
        ring_pend[p] = ring_pend[p] - 1'b1;
        r.dout = ring_data[p];
        items_taken[a.cid] = items_taken[a.cid] + 1'b1;
        rd_ptr[a.cid] = step_ptr(p);
      end
    end
    return r;
  endfunction

  task automatic flag(input string what);
    if (mismatches < 40) $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  function automatic logic [DW-1:0] rand_data();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return DW'($urandom);
    endcase
  endfunction

  function automatic void push_write(input logic [DW-1:0] d);
    access_t a;
    a.op = OP_WRITE;
    a.cid = CID_W'($urandom);
    a.din = d;
    access_q.push_back(a);
  endfunction

  function automatic void push_read(input int id);
    access_t a;
    a.op = OP_READ;
    a.cid = CID_W'(id);
    a.din = DW'($urandom);
    access_q.push_back(a);
  endfunction

  task automatic queue_mix(input int n);
    int wr_pct;
    int roll;
    wr_pct = 100 / (reader_count() + 1) + 10;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < wr_pct) push_write(rand_data());
      else if (roll < 92) push_read($urandom_range(0, reader_count() - 1));
      else push_read($urandom_range(0, NCONS - 1));
    end
  endtask

  task automatic drain();
    while (access_q.size() != 0 || in_valid || outcome_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [APB_AW-1:0] addr,
                          input logic [APB_DW-1:0] value, output logic [APB_DW-1:0] back);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    back = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] back;
    logic [APB_DW-1:0] mask;
    mask = (addr == ADDR_SLOTS) ? APB_DW'((1 << SLOTS_CW) - 1) : APB_DW'((1 << CONS_CW) - 1);
    apb_xfer(1'b1, addr, value, back);
    if (addr == ADDR_SLOTS) cfg_slots = value[SLOTS_CW-1:0];
    else cfg_cons = value[CONS_CW-1:0];
    apb_xfer(1'b0, addr, '0, back);
    if ((back & mask) !== (value & mask))
      flag($sformatf("register %0d reads %h, wrote %h", addr, back & mask, value & mask));
    @(negedge clk);
  endtask

  task automatic set_ring(input int slots, input int readers);
    cfg_write(ADDR_SLOTS, APB_DW'(slots));
    cfg_write(ADDR_CONS, APB_DW'(readers));
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // sender: bursts with random gaps
  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        outcome_q.push_back(ring_access(cur));
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, max_gap);
        end
      end
      if (!(in_valid && in_stall)) begin
        nv = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (access_q.size() > 0) begin
          cur = access_q.pop_front();
          nv = 1'b1;
          opcode <= cur.op;
          consumer_id <= cur.cid;
          data_in <= cur.din;
        end
        in_valid <= nv;
      end
    end
  end

  // receiver: check each result beat, stall on its own pattern
  always @(posedge clk) begin
    outcome_t want;
    logic ns;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          flag($sformatf("unexpected beat status=%0d data=%h", status, data_out));
        end else begin
          want = outcome_q.pop_front();
          if (status !== want.st)
            flag($sformatf("status %0d, want %0d", status, want.st));
          if (data_out !== want.dout)
            flag($sformatf("data_out %h, want %h", data_out, want.dout));
        end
      end
      ns = 1'b0;
      if (free_left > 0) begin
        free_left--;
      end else if (stall_left > 0) begin
        stall_left--;
        ns = 1'b1;
      end else begin
        case ($urandom_range(0, 3))
          0: free_left = $urandom_range(8, 40);
          1: begin
            stall_left = $urandom_range(0, max_stall - 1);
            ns = 1'b1;
          end
          default: ns = 1'b0;
        endcase
      end
      out_stall <= ns;
    end
  end

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      ring_data[i] = '0;
      ring_pend[i] = '0;
    end
    for (int i = 0; i < NCONS; i++) begin
      rd_ptr[i] = '0;
      items_taken[i] = '0;
    end
    wr_ptr = '0;
    items_made = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // one slot, one reader: alternate writes and reads, with refusals
    max_gap = 1;
    max_stall = 1;
    set_ring(1, 1);
    push_read(0);
    push_read(5);
    repeat (SINGLE_PAIRS) begin
      push_write(rand_data());
      if ($urandom_range(0, 7) == 0) push_write(rand_data());
      push_read(0);
      if ($urandom_range(0, 7) == 0) push_read(0);
    end
    drain();

    max_gap = 6;
    max_stall = 5;
    set_ring(16, 8);
    push_write('0);
    push_write('1);
    push_write(16'hA5A5);
    repeat (4) push_read(0);
    push_read(7);
    queue_mix(40);
    drain();
    queue_mix(40);
    drain();

    set_ring(2, 3);
    push_read(3);
    push_read(7);
    push_write(16'h5A5A);
    push_write(16'hC3C3);
    push_write(16'h3C3C);
    for (int c = 0; c < 3; c++) push_read(c);
    push_write(16'h0F0F);
    queue_mix(50);
    drain();

    // below range: saturate to one slot, one reader
    set_ring(0, 0);
    push_write(16'h1234);
    push_write(16'h4321);
    push_read(0);
    push_read(1);
    push_read(0);
    push_write(16'h8001);
    queue_mix(60);
    drain();

    // above range: saturate to full ring, all readers
    set_ring(31, 15);
    repeat (12) push_write(rand_data());
    queue_mix(50);
    drain();

    // shrink with pointers left beyond the ring
    set_ring(3, 8);
    queue_mix(50);
    drain();

    max_stall = 12;
    set_ring(9, 5);
    queue_mix(60);
    drain();

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
design/brb_pkg.sv
design/broadcast_ring_buffer.sv
design/brb_checker.sv
test/tb.sv
